// ===== design/i2cms_pkg.sv =====
// Shared types and constants of the I2C master bit sequencer.
// Holds the command and phase transfer structs and the opcode codes.
// No dependencies.
package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [15:0] HOLD_RESET = 16'd500;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_SEND  = 3'd1;
    localparam logic [2:0] OP_WACK  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_SACK  = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic [7:0] slave_levels;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       hold_follows;
        logic       sample_point;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       last;
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } seq_state_t;

endpackage

// ===== design/i2cms_cmd_front.sv =====
// Command front end: accepts commands, drops unknown opcodes and queues the rest.
// Depends on i2cms_pkg.
module i2cms_cmd_front
    import i2cms_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t cmd,
    output logic q_valid,
    input  logic q_pop,
    output cmd_t q_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            wr_en;
    logic            rd_en;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign wr_en   = push && !full && (cmd.opcode <= OP_STOP);
    assign rd_en   = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ===== design/i2cms_phase_gen.sv =====
// Phase generator: runs one queued command as a series of bus phases with hold timing.
// Keeps the bus line state and the result output register. Depends on i2cms_pkg.
module i2cms_phase_gen
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] hold_cycles,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_t        q_cmd,
    output logic        empty,
    input  logic        pop,
    output phase_t      phase
);

    seq_state_t  state_reg, state_next;
    logic [2:0]  op_reg;
    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  slv_reg, slv_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ackl_reg;
    logic [1:0]  step_reg, step_next;
    logic [2:0]  bit_reg, bit_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        dir_reg, dir_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    phase_t      phase_reg, phase_next;
    phase_t      ph;
    logic        emit;
    logic        bit_last;

    assign empty    = !out_valid_reg;
    assign phase    = phase_reg;
    assign emit     = (state_reg == ST_RUN) && (!out_valid_reg || pop);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign bit_last = (bit_reg == 3'(BITS_PER_BYTE - 1));

    // phase contents and line update for the current step
    always_comb
    begin
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        dir_next  = dir_reg;
        tx_next   = tx_reg;
        slv_next  = slv_reg;
        rx_next   = rx_reg;
        step_next = step_reg + 2'd1;
        bit_next  = bit_reg;
        ph        = '0;
        ph.hold_follows = 1'b1;
        case (op_reg)
            OP_START:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        dir_next = 1'b1;
                        sda_next = 1'b1;
                        ph.hold_follows = 1'b0;
                    end
                    2'd1: scl_next = 1'b1;
                    2'd2: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        ph.hold_follows = 1'b0;
                        ph.last = 1'b1;
                    end
                endcase
            end
            OP_SEND:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                    end
                    2'd1:
                    begin
                        sda_next = tx_reg[7];
                        tx_next  = {tx_reg[6:0], 1'b0};
                    end
                    2'd2: scl_next = 1'b1;
                    default:
                    begin
                        scl_next = 1'b0;
                        if (bit_last)
                        begin
                            ph.last = 1'b1;
                        end
                        else
                        begin
                            step_next = 2'd1;
                            bit_next  = bit_reg + 3'd1;
                        end
                    end
                endcase
            end
            OP_WACK:
            begin
                if (step_reg == 2'd0)
                begin
                    dir_next = 1'b0;
                    scl_next = 1'b0;
                end
                else
                begin
                    scl_next = 1'b1;
                    ph.sample_point = 1'b1;
                    ph.ack_seen = !slv_reg[7];
                    ph.last = 1'b1;
                end
            end
            OP_READ:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        dir_next = 1'b0;
                        scl_next = 1'b0;
                    end
                    2'd1:
                    begin
                        scl_next = 1'b1;
                        ph.sample_point = 1'b1;
                        rx_next  = {rx_reg[6:0], slv_reg[7]};
                        slv_next = {slv_reg[6:0], 1'b0};
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        if (bit_last)
                        begin
                            ph.last = 1'b1;
                            ph.read_byte = rx_reg;
                        end
                        else
                        begin
                            step_next = 2'd1;
                            bit_next  = bit_reg + 3'd1;
                        end
                    end
                endcase
            end
            OP_SACK:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                    end
                    2'd1: sda_next = ackl_reg;
                    default:
                    begin
                        scl_next = 1'b1;
                        ph.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                        ph.hold_follows = 1'b0;
                    end
                    2'd1: sda_next = 1'b0;
                    2'd2: scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        ph.last = 1'b1;
                    end
                endcase
            end
        endcase
        ph.scl_level = scl_next;
        ph.sda_drive = dir_next;
        ph.sda_level = dir_next & sda_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    phase_next     = ph;
                    done_next      = ph.last;
                    cnt_next       = hold_cycles;
                    if (ph.hold_follows)
                    begin
                        state_next = ST_HOLD;
                    end
                    else if (ph.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HOLD:
            begin
                cnt_next = cnt_reg - 16'd1;
                if (cnt_reg <= 16'd1)
                begin
                    state_next = done_reg ? ST_IDLE : ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            dir_reg       <= 1'b1;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            op_reg        <= OP_START;
            step_reg      <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            if (q_pop)
            begin
                op_reg   <= q_cmd.opcode;
                step_reg <= '0;
                bit_reg  <= '0;
            end
            else if (emit)
            begin
                scl_reg  <= scl_next;
                sda_reg  <= sda_next;
                dir_reg  <= dir_next;
                step_reg <= step_next;
                bit_reg  <= bit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        if (q_pop)
        begin
            tx_reg   <= q_cmd.tx_byte;
            slv_reg  <= q_cmd.slave_levels;
            ackl_reg <= q_cmd.ack_level;
            rx_reg   <= '0;
        end
        else if (emit)
        begin
            tx_reg  <= tx_next;
            slv_reg <= slv_next;
            rx_reg  <= rx_next;
        end
    end

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
// The first phase of a command reaches the result port through the idle-state load from
// the queue and the phase output register. Throughput: one phase per cycle while the
// result port is popped; a phase with hold_follows set is followed by a hold state timed
// by the hold register, and each command is loaded from the queue in the idle state.
// Reset: queue and result port empty, bus lines idle high, SDA driven, hold register at HOLD_RESET.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  cmd_t        cmd,
    output logic        empty,
    input  logic        pop,
    output phase_t      phase,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] hold_reg;
    logic        q_valid;
    logic        q_pop;
    cmd_t        q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            hold_reg <= cfg_wr_data;
        end
    end

    i2cms_cmd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    i2cms_phase_gen u_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold_cycles (hold_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_cmd       (q_cmd),
        .empty       (empty),
        .pop         (pop),
        .phase       (phase)
    );

endmodule

// ===== design/i2cms_checker.sv =====
// Port-level checks of the I2C master bit sequencer, bound to the top level.
// Depends on i2cms_pkg and i2c_master_bit_sequencer.
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   empty,
    input logic   pop,
    input phase_t phase
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(phase)))
        else $error("result changed before transfer");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !phase.sda_drive) |-> !phase.sda_level)
        else $error("SDA level set while released");

    a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && phase.ack_seen) |->
            (phase.sample_point && phase.last && !phase.sda_drive && phase.scl_level))
        else $error("ack reported outside final sample phase");

    a_byte_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (phase.read_byte != 8'd0)) |->
            (phase.last && !phase.scl_level && !phase.sda_drive))
        else $error("read byte outside final read phase");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .phase (phase)
);
